// ===== rtl/core/lpg_pkg.sv =====
package lpg_pkg;

   // Fixed width of every coordinate port.
   localparam int FIELD_BITS = 6;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

// ===== rtl/core/line_pixel_generator_unit.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// req      | in        | req_valid/ready    | start_x, start_y, end_x, end_y (6b each)
// rsp      | out       | rsp_valid/ready    | pixel_x, pixel_y (6b), last_pixel (1b)
//
// One line is taken at a time; req_ready is high only while the block is idle.
// A line with major span d goes through setup, then a walk over its d+1 pixels in
// which the error adder produces one pixel per cycle into the point buffer,
// then emits min(d+1, MAX_POINTS) pixels, holding while rsp_ready is low,
// then returns to idle, where the next line can be taken.
// Reset (synchronous, active high) returns the sequencer to idle with no item
// pending; the point buffer needs no clearing. A stall on rsp holds the
// current pixel and the buffer read address.
module line_pixel_generator_unit
   import lpg_pkg::*;
#(
   parameter int COORD_BITS = 6,
   parameter int MAX_POINTS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_start_x,
   input  logic [FIELD_BITS-1:0] req_start_y,
   input  logic [FIELD_BITS-1:0] req_end_x,
   input  logic [FIELD_BITS-1:0] req_end_y,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FIELD_BITS-1:0] rsp_pixel_x,
   output logic [FIELD_BITS-1:0] rsp_pixel_y,
   output logic                  rsp_last_pixel
);

   localparam int CB = COORD_BITS;
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int SW = ((CB > AW) ? CB : AW) + 1;   // slot width, holds MAX_POINTS
   localparam int EW = CB + 2;                      // signed error width

   // Sequencer and per-line registers
   state_type            state_ff, state_in;
   logic [CB-1:0]        sx_ff, sy_ff, ex_ff, ey_ff;
   logic [CB-1:0]        sx_in, sy_in, ex_in, ey_in;
   logic                 steep_ff, steep_in;
   logic                 rev_ff, rev_in;
   logic                 mup_ff, mup_in;
   logic [CB-1:0]        a0_ff, a0_in;
   logic [CB-1:0]        minor_ff, minor_in;
   logic [CB-1:0]        dmaj_ff, dmaj_in;
   logic [CB-1:0]        dmin_ff, dmin_in;
   logic signed [EW-1:0] err_ff, err_in;
   logic [CB-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        kept_last_ff, kept_last_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;

   // Point buffer
   logic [2*CB-1:0]      point_mem [MAX_POINTS];
   logic [2*CB-1:0]      rdata_ff;

   // Setup datapath
   logic [CB-1:0]        span_x, span_y;
   logic                 steep_c, rev_c;
   logic [CB-1:0]        a0s, a1s, b0s, b1s;
   logic [CB-1:0]        a0c, a1c, b0c, b1c;
   logic [CB-1:0]        dmaj_c;

   // Walk datapath
   logic [CB-1:0]        maj;
   logic [CB-1:0]        px, py;
   logic [SW-1:0]        slot;
   logic                 slot_we;
   logic signed [EW-1:0] err_sub;
   logic                 walk_done;

   logic                 rsp_take;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_take  = rsp_valid && rsp_ready;

   // Setup: find the major axis, then order the end points low to high on it.
   always_comb begin
      span_x  = (sx_ff > ex_ff) ? (sx_ff - ex_ff) : (ex_ff - sx_ff);
      span_y  = (sy_ff > ey_ff) ? (sy_ff - ey_ff) : (ey_ff - sy_ff);
      steep_c = span_y > span_x;
      a0s     = steep_c ? sy_ff : sx_ff;
      b0s     = steep_c ? sx_ff : sy_ff;
      a1s     = steep_c ? ey_ff : ex_ff;
      b1s     = steep_c ? ex_ff : ey_ff;
      rev_c   = a0s > a1s;
      a0c     = rev_c ? a1s : a0s;
      a1c     = rev_c ? a0s : a1s;
      b0c     = rev_c ? b1s : b0s;
      b1c     = rev_c ? b0s : b1s;
      dmaj_c  = a1c - a0c;
   end

   // Walk: one pixel per cycle through the error adder.
   always_comb begin
      maj       = a0_ff + idx_ff;
      px        = steep_ff ? minor_ff : maj;
      py        = steep_ff ? maj : minor_ff;
      slot      = rev_ff ? SW'(dmaj_ff - idx_ff) : SW'(idx_ff);
      slot_we   = slot < SW'(MAX_POINTS);
      err_sub   = err_ff - $signed({2'b00, dmin_ff});
      walk_done = (idx_ff == dmaj_ff);
   end

   always_comb begin
      state_in     = state_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      steep_in     = steep_ff;
      rev_in       = rev_ff;
      mup_in       = mup_ff;
      a0_in        = a0_ff;
      minor_in     = minor_ff;
      dmaj_in      = dmaj_ff;
      dmin_in      = dmin_ff;
      err_in       = err_ff;
      idx_in       = idx_ff;
      kept_last_in = kept_last_ff;
      rd_ptr_in    = rd_ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            // latch the line, masked to the coordinate width
            if (req_valid) begin
               sx_in    = req_start_x[CB-1:0];
               sy_in    = req_start_y[CB-1:0];
               ex_in    = req_end_x[CB-1:0];
               ey_in    = req_end_y[CB-1:0];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            steep_in = steep_c;
            rev_in   = rev_c;
            a0_in    = a0c;
            minor_in = b0c;
            mup_in   = b0c < b1c;
            dmaj_in  = dmaj_c;
            dmin_in  = (b0c > b1c) ? (b0c - b1c) : (b1c - b0c);
            err_in   = $signed({2'b00, dmaj_c >> 1});
            idx_in   = '0;
            // clip the run to the buffer depth
            if (SW'(dmaj_c) >= SW'(MAX_POINTS - 1)) begin
               kept_last_in = AW'(MAX_POINTS - 1);
            end else begin
               kept_last_in = AW'(dmaj_c);
            end
            state_in = ST_WALK;
         end
         ST_WALK: begin
            // advance the error; step the minor axis when it goes negative
            if (err_sub < 0) begin
               minor_in = mup_ff ? (minor_ff + 1'b1) : (minor_ff - 1'b1);
               err_in   = err_sub + $signed({2'b00, dmaj_ff});
            end else begin
               err_in   = err_sub;
            end
            idx_in = idx_ff + 1'b1;
            if (walk_done) begin
               rd_ptr_in = '0;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold the address on a stall, advance on a taken item
            if (rsp_take) begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
               if (rd_ptr_ff == kept_last_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      steep_ff     <= steep_in;
      rev_ff       <= rev_in;
      mup_ff       <= mup_in;
      a0_ff        <= a0_in;
      minor_ff     <= minor_in;
      dmaj_ff      <= dmaj_in;
      dmin_ff      <= dmin_in;
      err_ff       <= err_in;
      idx_ff       <= idx_in;
      kept_last_ff <= kept_last_in;
      rd_ptr_ff    <= rd_ptr_in;
   end

   // Point buffer: written during the walk, read from the next read address into a register that drives the output.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_WALK) && slot_we) begin
         point_mem[slot[AW-1:0]] <= {px, py};
      end
      // forward a pixel written this cycle at the address being read
      if ((state_ff == ST_WALK) && slot_we && (slot[AW-1:0] == rd_ptr_in)) begin
         rdata_ff <= {px, py};
      end else begin
         rdata_ff <= point_mem[rd_ptr_in];
      end
   end

   assign rsp_pixel_x    = FIELD_BITS'(rdata_ff[2*CB-1:CB]);
   assign rsp_pixel_y    = FIELD_BITS'(rdata_ff[CB-1:0]);
   assign rsp_last_pixel = (rd_ptr_ff == kept_last_ff);

   // A taken line leaves the block busy with no pixel shown in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("line accept did not enter setup");

   // The last pixel taken returns the block to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_pixel |=> req_ready && !rsp_valid)
      else $error("block not idle after last pixel");

   // The read pointer never passes the clipped run length.
   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rd_ptr_ff <= kept_last_ff)
      else $error("read pointer past end of run");

   // The walk index never passes the major span.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> idx_ff <= dmaj_ff)
      else $error("walk index past major span");

   // A stalled pixel holds its buffer address.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rd_ptr_ff) && rsp_valid)
      else $error("read address moved under stall");

endmodule

// ===== sim/line_pixel_generator_unit_tb.sv =====
module line_pixel_generator_unit_tb;
   import lpg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_MAX     = (1 << FIELD_BITS) - 1;
   localparam int RUN_DEPTH     = 64;
   localparam int RANDOM_LINES  = 410;
   localparam int QUIET_LINES   = 40;
   localparam int PRESSURE_AT   = 50;
   localparam int PRESSURE_HOLD = 600;
   localparam int DRAIN_CYCLES  = 160;
   localparam int CYCLE_LIMIT   = 3_000_000;

   // One expected pixel of a rasterized line.
   typedef struct packed {
      logic [FIELD_BITS-1:0] x;
      logic [FIELD_BITS-1:0] y;
      logic                  last;
   } pixel_rec_type;

   // One row of the directed table. With single_point set, the expected run
   // is typed in as the start point alone, marked last.
   typedef struct {
      logic [FIELD_BITS-1:0] sx;
      logic [FIELD_BITS-1:0] sy;
      logic [FIELD_BITS-1:0] ex;
      logic [FIELD_BITS-1:0] ey;
      bit                    single_point;
   } line_row_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [FIELD_BITS-1:0] req_start_x    = '0;
   logic [FIELD_BITS-1:0] req_start_y    = '0;
   logic [FIELD_BITS-1:0] req_end_x      = '0;
   logic [FIELD_BITS-1:0] req_end_y      = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [FIELD_BITS-1:0] rsp_pixel_x;
   logic [FIELD_BITS-1:0] rsp_pixel_y;
   logic                  rsp_last_pixel;

   // Pixels still owed by the block, oldest first.
   pixel_rec_type pending_pixels[$];

   // Predictor's copy of the block state.
   logic [2*FIELD_BITS-1:0] run_store[RUN_DEPTH];
   logic [7:0]              walk_error;
   logic [FIELD_BITS-1:0]   walk_major;
   logic [FIELD_BITS-1:0]   walk_minor;

   int  error_count    = 0;
   int  lines_accepted = 0;
   int  pixels_checked = 0;
   int  longest_hold   = 0;
   bit  quiet_tail     = 1'b0;
   bit  pressure_done  = 1'b0;
   int  stall_left     = 0;
   int  hold_run       = 0;

   line_pixel_generator_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_start_x    (req_start_x),
      .req_start_y    (req_start_y),
      .req_end_x      (req_end_x),
      .req_end_y      (req_end_y),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Rasterize one line and queue its pixels in output order. Walk the major
   // axis from the lower end; store each pixel at its slot so a line drawn
   // backwards still comes out starting at its start point.
   function automatic void predict_line_pixels(input logic [FIELD_BITS-1:0] sx,
                                               input logic [FIELD_BITS-1:0] sy,
                                               input logic [FIELD_BITS-1:0] ex,
                                               input logic [FIELD_BITS-1:0] ey);
      int a0, b0, a1, b1, t;
      int span_x, span_y, dmaj, dmin, err, minor, minor_step, maj, count, i, slot;
      bit steep, backwards;
      logic [FIELD_BITS-1:0] px, py;
      pixel_rec_type rec;

      span_x = int'(ex) - int'(sx);
      span_y = int'(ey) - int'(sy);
      if (span_x < 0) span_x = -span_x;
      if (span_y < 0) span_y = -span_y;
      // Equal spans stay shallow.
      steep = span_y > span_x;
      if (steep) begin
         a0 = int'(sy); b0 = int'(sx); a1 = int'(ey); b1 = int'(ex);
      end else begin
         a0 = int'(sx); b0 = int'(sy); a1 = int'(ex); b1 = int'(ey);
      end
      backwards = a0 > a1;
      if (backwards) begin
         t = a0; a0 = a1; a1 = t;
         t = b0; b0 = b1; b1 = t;
      end

      dmaj       = a1 - a0;
      dmin       = (b1 > b0) ? b1 - b0 : b0 - b1;
      err        = dmaj / 2;
      minor      = b0;
      minor_step = (b0 < b1) ? 1 : -1;
      count      = dmaj + 1;
      if (count > RUN_DEPTH) count = RUN_DEPTH;

      i = 0;
      for (maj = a0; maj <= a1; maj++) begin
         px   = steep ? minor[FIELD_BITS-1:0] : maj[FIELD_BITS-1:0];
         py   = steep ? maj[FIELD_BITS-1:0] : minor[FIELD_BITS-1:0];
         slot = backwards ? (dmaj - i) : i;
         if (slot >= 0 && slot < count) run_store[slot] = {px, py};
         err -= dmin;
         if (err < 0) begin
            minor += minor_step;
            err   += dmaj;
         end
         i++;
      end
      walk_error = err[7:0];
      walk_major = maj[FIELD_BITS-1:0];
      walk_minor = minor[FIELD_BITS-1:0];

      for (i = 0; i < count; i++) begin
         rec.x    = run_store[i][2*FIELD_BITS-1:FIELD_BITS];
         rec.y    = run_store[i][FIELD_BITS-1:0];
         rec.last = (i == count - 1);
         pending_pixels.insert(pending_pixels.size(), rec);
      end
   endfunction

   // Offer one line, optionally after a random idle burst, and hold it until
   // the block takes it. Queue its expected run at acceptance.
   task automatic offer_line(input line_row_type row);
      pixel_rec_type rec;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_start_x <= row.sx;
      req_start_y <= row.sy;
      req_end_x   <= row.ex;
      req_end_y   <= row.ey;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      lines_accepted++;
      if (row.single_point) begin
         rec.x    = row.sx;
         rec.y    = row.sy;
         rec.last = 1'b1;
         pending_pixels.insert(pending_pixels.size(), rec);
      end else begin
         predict_line_pixels(row.sx, row.sy, row.ex, row.ey);
      end
   endtask

   // Move a coordinate by a signed offset and clamp it to the grid.
   function automatic logic [FIELD_BITS-1:0] nudge(input logic [FIELD_BITS-1:0] base,
                                                   input int offset);
      int v;
      v = int'(base) + offset;
      if (v < 0) v = 0;
      if (v > COORD_MAX) v = COORD_MAX;
      return v[FIELD_BITS-1:0];
   endfunction

   // Random line: mostly short lines in every octant, then full-grid lines,
   // single points and axis-aligned runs.
   function automatic line_row_type random_line();
      line_row_type row;
      int mode;
      mode             = $urandom_range(0, 99);
      row.single_point = 1'b0;
      row.sx           = FIELD_BITS'($urandom_range(0, COORD_MAX));
      row.sy           = FIELD_BITS'($urandom_range(0, COORD_MAX));
      row.ex           = FIELD_BITS'($urandom_range(0, COORD_MAX));
      row.ey           = FIELD_BITS'($urandom_range(0, COORD_MAX));
      if (mode < 60) begin
         row.ex = nudge(row.sx, $urandom_range(0, 14) - 7);
         row.ey = nudge(row.sy, $urandom_range(0, 14) - 7);
      end else if (mode < 85) begin
         // keep the full-grid endpoints
      end else if (mode < 92) begin
         row.ex = row.sx;
         row.ey = row.sy;
      end else if (mode < 96) begin
         row.ey = row.sy;
      end else begin
         row.ex = row.sx;
      end
      return row;
   endfunction

   // Directed lines: single points, grid edges in both directions, the four
   // diagonals, steep and shallow lines with a falling minor axis, near-equal
   // spans, two-pixel lines and alternating bit patterns.
   line_row_type directed_lines[] = '{
      '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1},
      '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1},
      '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1},
      '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0},
      '{6'd63, 6'd63, 6'd0,  6'd63, 1'b0},
      '{6'd0,  6'd0,  6'd0,  6'd63, 1'b0},
      '{6'd63, 6'd63, 6'd63, 6'd0,  1'b0},
      '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0},
      '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0},
      '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0},
      '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0},
      '{6'd40, 6'd5,  6'd30, 6'd50, 1'b0},
      '{6'd30, 6'd50, 6'd40, 6'd5,  1'b0},
      '{6'd5,  6'd40, 6'd50, 6'd30, 1'b0},
      '{6'd50, 6'd30, 6'd5,  6'd40, 1'b0},
      '{6'd10, 6'd10, 6'd13, 6'd7,  1'b0},
      '{6'd0,  6'd0,  6'd63, 6'd62, 1'b0},
      '{6'd0,  6'd0,  6'd62, 6'd63, 1'b0},
      '{6'd20, 6'd20, 6'd21, 6'd20, 1'b0},
      '{6'd20, 6'd20, 6'd20, 6'd19, 1'b0},
      '{6'd21, 6'd42, 6'd42, 6'd21, 1'b0},
      '{6'd42, 6'd21, 6'd21, 6'd42, 1'b0}
   };

   // Receiver: random stall bursts, plus one long hold once enough lines
   // went through, so the block fills up and drops req_ready while the
   // sender keeps offering. Stall nothing in the quiet tail.
   always @(posedge clock) begin
      if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_ready  <= 1'b1;
      end else if (!pressure_done && lines_accepted >= PRESSURE_AT) begin
         pressure_done <= 1'b1;
         stall_left    <= PRESSURE_HOLD;
         rsp_ready     <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < 15) begin
         stall_left <= $urandom_range(1, 17);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Track the longest stretch of back-pressure for the summary.
   always @(posedge clock) begin
      if (!rsp_ready) begin
         hold_run <= hold_run + 1;
         if (hold_run + 1 > longest_hold) longest_hold <= hold_run + 1;
      end else begin
         hold_run <= 0;
      end
   end

   // Check every accepted pixel against the oldest expectation.
   always @(posedge clock) begin
      pixel_rec_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_error($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                   rsp_pixel_x, rsp_pixel_y, rsp_last_pixel));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.x)
               report_error($sformatf("pixel_x got %0d want %0d", rsp_pixel_x, want.x));
            if (rsp_pixel_y !== want.y)
               report_error($sformatf("pixel_y got %0d want %0d", rsp_pixel_y, want.y));
            if (rsp_last_pixel !== want.last)
               report_error($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
                                      rsp_last_pixel, want.last, want.x, want.y));
         end
         pixels_checked++;
      end
   end

   // Watchdog: end the run if it never drains.
   initial begin : watchdog
      int cycle_count;
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("timeout after %0d cycles, %0d pixels outstanding",
               CYCLE_LIMIT, pending_pixels.size());
      $display("line_pixel_generator_unit regression: fail");
      $finish;
   end

   initial begin : stimulus
      int i;
      // Hold reset, then release it.
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_lines[row_idx]) offer_line(directed_lines[row_idx]);

      for (i = 0; i < RANDOM_LINES; i++) begin
         // Drop all idling for the last stretch of lines.
         if (i == RANDOM_LINES - QUIET_LINES) quiet_tail = 1'b1;
         offer_line(random_line());
      end
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray pixel.
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d lines (%0d directed) and checked %0d pixels",
               lines_accepted, directed_lines.size(), pixels_checked);
      $display("longest receiver hold %0d cycles, %0d errors", longest_hold, error_count);
      if (error_count == 0) begin
         $display("line_pixel_generator_unit regression: pass");
      end else begin
         $display("line_pixel_generator_unit regression: fail");
      end
      $finish;
   end

endmodule
